// ===== design/ipv4_dotted_decimal_parser_unit_assert.svh =====
// ---------------------------------------------------------------------------
// Assertion macros for the dotted-quad parser
// Clocked, reset-qualified property checks with $error reporting.
// ---------------------------------------------------------------------------
`ifndef IPV4_DOTTED_DECIMAL_PARSER_UNIT_ASSERT_SVH
`define IPV4_DOTTED_DECIMAL_PARSER_UNIT_ASSERT_SVH

// Same-cycle implication, checked at every clock edge outside reset.
`define IPV4DP_ASSERT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication, checked at every clock edge outside reset.
`define IPV4DP_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error(msg);

// Delayed implication, checked at every clock edge outside reset.
`define IPV4DP_ASSERT_DLY2(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> ##2 (cons)) \
    else $error(msg);

`endif

// ===== design/ipv4dp_pkg.sv =====
// ---------------------------------------------------------------------------
// ipv4dp_pkg
// Types and constants shared by the dotted-quad address parser.
// ---------------------------------------------------------------------------
package ipv4dp_pkg;

  localparam int unsigned CharW   = 8;
  localparam int unsigned AddrW   = 32;
  localparam int unsigned OctetW  = 8;
  localparam int unsigned AccW    = 10;
  // Only the first three octets are ever stored before the final one arrives.
  localparam int unsigned PackedW = 24;

  localparam logic [CharW-1:0]  ChNul   = 8'h00;
  localparam logic [CharW-1:0]  ChZero  = 8'h30;
  localparam logic [CharW-1:0]  ChNine  = 8'h39;
  localparam logic [CharW-1:0]  ChDot   = 8'h2E;
  localparam logic [AccW-1:0]   OctMax  = 10'd255;
  localparam logic [1:0]        LastOct = 2'd3;
  localparam logic [1:0]        MaxDig  = 2'd3;

  typedef struct packed {
    logic [1:0]         octet_index;
    logic [1:0]         digit_count;
    logic [AccW-1:0]    octet_value;
    logic [PackedW-1:0] packed_address;
    logic               error_seen;
  } parse_state_t;

  typedef struct packed {
    logic [AddrW-1:0] address;
    logic             invalid;
  } parse_result_t;

  // Handshake between the input register and the parse stage.
  typedef struct packed {
    logic valid;   // input register holds a character
    logic is_nul;  // that character ends the string
  } in_status_t;

endpackage

// ===== design/ipv4_dotted_decimal_parser_unit.sv =====
// ---------------------------------------------------------------------------
// ipv4_dotted_decimal_parser_unit
// Streaming parser for strict dotted-quad IPv4 address strings.
// ---------------------------------------------------------------------------
// Usage: characters arrive one per word on the slave stream, a NUL word ends
// each string. For every NUL the block returns one word on the master stream:
// the packed address with the first octet in bits 7:0, or zero with the
// invalid flag (tuser) raised when the string was not a legal dotted quad.
// Other characters produce no output word.
//
// Throughput is one character per cycle unless a NUL waits for the output
// register. Each character passes through an input register and a single
// pass of parse logic (a multiply-by-ten accumulate and a compare) that
// updates the parser state and loads a NUL's result into the output register.
//
// Reset clears the parser state and both stream valid flags, so the first word
// after reset starts a new string. When the receiver stalls, the result word
// is held in the output register; non-NUL characters keep flowing, and only a
// further NUL waits in the input register until the output word is taken.
// ---------------------------------------------------------------------------
module ipv4_dotted_decimal_parser_unit
  import ipv4dp_pkg::*;
(
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        s_axis_tvalid_i,
  output logic        s_axis_tready_o,
  input  logic [7:0]  s_axis_tdata_i,   // [7:0] char_in
  output logic        m_axis_tvalid_o,
  input  logic        m_axis_tready_i,
  output logic [31:0] m_axis_tdata_o,   // [31:0] address
  output logic        m_axis_tuser_o    // [0] invalid
);

  in_status_t       in_status;
  logic [CharW-1:0] in_char;
  logic             out_free;
  logic             advance;
  logic             emit;

  parse_state_t  state_q, state_d, state_next;
  parse_result_t step_result, out_result;

  // Input register; a waiting NUL only moves on when the result slot is free.
  ipv4dp_in_reg u_in_reg (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .s_valid_i (s_axis_tvalid_i),
    .s_ready_o (s_axis_tready_o),
    .s_char_i  (s_axis_tdata_i),
    .advance_i (advance),
    .status_o  (in_status),
    .char_o    (in_char)
  );

  assign advance = in_status.valid && (!in_status.is_nul || out_free);
  assign emit    = advance && in_status.is_nul;

  ipv4dp_step u_step (
    .state_i  (state_q),
    .char_i   (in_char),
    .state_o  (state_next),
    .result_o (step_result)
  );

  assign state_d = advance ? state_next : state_q;

  // Parser state is all control and is cleared by reset.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= '0;
    end else begin
      state_q <= state_d;
    end
  end

  ipv4dp_out_reg u_out_reg (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .load_i    (emit),
    .result_i  (step_result),
    .free_o    (out_free),
    .m_valid_o (m_axis_tvalid_o),
    .m_ready_i (m_axis_tready_i),
    .result_o  (out_result)
  );

  assign m_axis_tdata_o = out_result.address;
  assign m_axis_tuser_o = out_result.invalid;

endmodule

// ===== design/ipv4dp_in_reg.sv =====
// ---------------------------------------------------------------------------
// ipv4dp_in_reg
// Input register for incoming characters with ready generation.
// ---------------------------------------------------------------------------
module ipv4dp_in_reg
  import ipv4dp_pkg::*;
(
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             s_valid_i,
  output logic             s_ready_o,
  input  logic [CharW-1:0] s_char_i,
  input  logic             advance_i,
  output in_status_t       status_o,
  output logic [CharW-1:0] char_o
);

  logic             valid_q, valid_d;
  logic [CharW-1:0] char_q;
  logic             load;

  assign s_ready_o = !valid_q || advance_i;
  assign load      = s_valid_i && s_ready_o;
  assign valid_d   = load || (valid_q && !advance_i);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else begin
      valid_q <= valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (load) begin
      char_q <= s_char_i;
    end
  end

  assign status_o.valid  = valid_q;
  assign status_o.is_nul = (char_q == ChNul);
  assign char_o          = char_q;

endmodule

// ===== design/ipv4dp_step.sv =====
// ---------------------------------------------------------------------------
// ipv4dp_step
// Per-character parse update: next state and end-of-string result.
// ---------------------------------------------------------------------------
module ipv4dp_step
  import ipv4dp_pkg::*;
(
  input  parse_state_t     state_i,
  input  logic [CharW-1:0] char_i,
  output parse_state_t     state_o,
  output parse_result_t    result_o
);

  logic            is_nul, is_dot, is_digit;
  logic [3:0]      digit;
  logic [AccW-1:0] acc_next;
  logic [PackedW-1:0] shifted;
  logic            ok;

  assign is_nul   = (char_i == ChNul);
  assign is_dot   = (char_i == ChDot);
  assign is_digit = (char_i >= ChZero) && (char_i <= ChNine);
  assign digit    = char_i[3:0];

  // value * 10 + digit, kept to the accumulator width
  assign acc_next = (state_i.octet_value << 3) + (state_i.octet_value << 1)
                  + {{(AccW-4){1'b0}}, digit};

  always_comb begin
    shifted = '0;
    case (state_i.octet_index)
      2'd0:    shifted[7:0]   = state_i.octet_value[OctetW-1:0];
      2'd1:    shifted[15:8]  = state_i.octet_value[OctetW-1:0];
      2'd2:    shifted[23:16] = state_i.octet_value[OctetW-1:0];
      default: shifted        = '0;
    endcase
  end

  assign ok = !state_i.error_seen && (state_i.octet_index == LastOct)
           && (state_i.digit_count != 2'd0) && (state_i.octet_value <= OctMax);

  always_comb begin
    result_o.address = ok ? {state_i.octet_value[OctetW-1:0], state_i.packed_address}
                          : '0;
    result_o.invalid = !ok;
  end

  always_comb begin
    state_o = state_i;
    if (is_nul) begin
      state_o = '0;
    end else if (!state_i.error_seen) begin
      if (is_dot) begin
        if (state_i.digit_count == 2'd0 || state_i.octet_index == LastOct
            || state_i.octet_value > OctMax) begin
          state_o.error_seen = 1'b1;
        end else begin
          state_o.packed_address = state_i.packed_address | shifted;
          state_o.octet_index    = state_i.octet_index + 2'd1;
          state_o.digit_count    = 2'd0;
          state_o.octet_value    = '0;
        end
      end else if (is_digit) begin
        if (state_i.digit_count == MaxDig) begin
          state_o.error_seen = 1'b1;
        end else begin
          state_o.octet_value = acc_next;
          state_o.digit_count = state_i.digit_count + 2'd1;
        end
      end else begin
        state_o.error_seen = 1'b1;
      end
    end
  end

endmodule

// ===== design/ipv4dp_out_reg.sv =====
// ---------------------------------------------------------------------------
// ipv4dp_out_reg
// Result register holding one parsed address until the receiver takes it.
// ---------------------------------------------------------------------------
module ipv4dp_out_reg
  import ipv4dp_pkg::*;
(
  input  logic          clk_i,
  input  logic          rst_ni,
  input  logic          load_i,
  input  parse_result_t result_i,
  output logic          free_o,
  output logic          m_valid_o,
  input  logic          m_ready_i,
  output parse_result_t result_o
);

  logic          valid_q, valid_d;
  parse_result_t result_q;

  assign free_o  = !valid_q || m_ready_i;
  assign valid_d = load_i || (valid_q && !m_ready_i);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else begin
      valid_q <= valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (load_i) begin
      result_q <= result_i;
    end
  end

  assign m_valid_o = valid_q;
  assign result_o  = result_q;

endmodule

// ===== design/ipv4dp_checker.sv =====
// ---------------------------------------------------------------------------
// ipv4dp_checker
// Port-level checks for the dotted-quad parser, bound to the top level.
// ---------------------------------------------------------------------------
`include "ipv4_dotted_decimal_parser_unit_assert.svh"

module ipv4dp_checker (
  input logic        clk_i,
  input logic        rst_ni,
  input logic        s_axis_tvalid_i,
  input logic        s_axis_tready_o,
  input logic [7:0]  s_axis_tdata_i,
  input logic        m_axis_tvalid_o,
  input logic        m_axis_tready_i,
  input logic [31:0] m_axis_tdata_o,
  input logic        m_axis_tuser_o
);

  logic out_stall;
  logic nul_in;

  assign out_stall = m_axis_tvalid_o && !m_axis_tready_i;
  assign nul_in    = s_axis_tvalid_i && s_axis_tready_o && (s_axis_tdata_i == 8'h00);

  // A stalled result word must stay put.
  `IPV4DP_ASSERT_NEXT(a_out_hold, out_stall, m_axis_tvalid_o && $stable(m_axis_tdata_o) && $stable(m_axis_tuser_o), "result word changed while stalled")

  // An invalid string always reports a zero address.
  `IPV4DP_ASSERT(a_invalid_zero, m_axis_tvalid_o && m_axis_tuser_o, m_axis_tdata_o == 32'd0, "invalid result carries a non-zero address")

  // With the output empty nothing can hold the input back.
  `IPV4DP_ASSERT(a_ready_when_idle, !m_axis_tvalid_o, s_axis_tready_o, "input stalled while output is empty")

  // A NUL taken with the output empty yields a result once it has passed the input and output registers.
  `IPV4DP_ASSERT_DLY2(a_nul_result, nul_in && !m_axis_tvalid_o, m_axis_tvalid_o, "no result after end of string")

endmodule

bind ipv4_dotted_decimal_parser_unit ipv4dp_checker u_ipv4dp_checker (.*);
